[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 byte stream hash unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Source of the byte shifted into the block window.
  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_PAD_MARK,
    SRC_ZERO,
    SRC_LENGTH
  } byte_src_t;

  typedef struct packed {
    logic      load;         // shift one byte into the block window
    byte_src_t src;
    logic      count;        // message byte: advance the byte count
    logic      init_rounds;  // working variables take the chained hash
    logic      round;        // one compression round
    logic [5:0] rnd;
    logic      add;          // fold working variables into the hash
    logic      restart;      // back to the initial vector, count cleared
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill_pos;
  } dp_status_t;

  localparam logic [31:0] INIT_VECTOR [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS      = 6'd63;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [5:0] MAX_MARK_POS  = 6'd55;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

endpackage

[rtl/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, round count and digest readout.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_byte_valid,
  input  logic       in_eom,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_idx,
  output logic       out_last,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t     state;
  logic [5:0] rnd;
  logic       eom_pend;
  logic       pad_mode;
  logic       pad_mark;
  logic       len_ok;
  logic       fin;
  logic       accept;
  logic       fills;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign out_idx   = rnd[2:0];
  assign out_last  = (rnd[2:0] == LAST_WORD_IDX);
  assign fills     = ((state == ST_PAD) || (accept && in_byte_valid)) &&
                     (status.fill_pos == LAST_POS);

  always_comb begin
    cmd             = '0;
    cmd.src         = SRC_INPUT;
    cmd.rnd         = rnd;
    cmd.out_idx     = rnd[2:0];
    case (state)
      ST_IDLE: begin
        cmd.load  = accept && in_byte_valid;
        cmd.count = accept && in_byte_valid;
      end
      ST_PAD: begin
        cmd.load = 1'b1;
        if (pad_mark) begin
          cmd.src = SRC_PAD_MARK;
        end else if (len_ok && status.fill_pos >= LEN_POS) begin
          cmd.src = SRC_LENGTH;
        end else begin
          cmd.src = SRC_ZERO;
        end
      end
      ST_ROUNDS: cmd.round = 1'b1;
      ST_ADD:    cmd.add = 1'b1;
      ST_OUT:    cmd.restart = out_ready && out_last;
      default: ;
    endcase
    cmd.init_rounds = fills;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rnd      <= '0;
      eom_pend <= 1'b0;
      pad_mode <= 1'b0;
      pad_mark <= 1'b0;
      len_ok   <= 1'b0;
      fin      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (fills) begin
              state    <= ST_ROUNDS;
              rnd      <= '0;
              eom_pend <= in_eom;
              fin      <= 1'b0;
            end else if (in_eom) begin
              state    <= ST_PAD;
              pad_mode <= 1'b1;
              pad_mark <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pad_mark <= 1'b0;
          // the length fits behind the mark only up to position 55
          if (pad_mark) begin
            len_ok <= (status.fill_pos <= MAX_MARK_POS);
          end
          if (fills) begin
            state <= ST_ROUNDS;
            rnd   <= '0;
            fin   <= len_ok && !pad_mark;
          end
        end
        ST_ROUNDS: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          rnd <= '0;
          if (fin) begin
            state <= ST_OUT;
          end else if (pad_mode) begin
            state  <= ST_PAD;
            len_ok <= 1'b1;
          end else if (eom_pend) begin
            state    <= ST_PAD;
            eom_pend <= 1'b0;
            pad_mode <= 1'b1;
            pad_mark <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (out_last) begin
              state    <= ST_IDLE;
              rnd      <= '0;
              pad_mode <= 1'b0;
              fin      <= 1'b0;
            end else begin
              rnd <= rnd + 6'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/sha256_dp.sv]
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block window, message schedule, round logic and chained hash.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [31:0] digest_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Window: bytes shift in at the low end of word 15 during intake. In rounds
  // 0..15 word 0 holds W[t]; later it holds W[t-16..t-1], oldest in word 0.
  logic [31:0] win [16];
  logic [31:0] rv [8];
  logic [31:0] hash [8];
  logic [5:0]  fill_pos;
  logic [60:0] byte_count;

  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  byte_in;
  logic [31:0] w_new;
  logic [31:0] w_t;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign status.fill_pos = fill_pos;
  assign digest_word     = hash[cmd.out_idx];

  assign bit_len = {byte_count, 3'b000};
  assign len_sel = ~fill_pos[2:0];

  always_comb begin
    case (cmd.src)
      SRC_INPUT:    byte_in = in_byte;
      SRC_PAD_MARK: byte_in = PAD_MARK_BYTE;
      SRC_LENGTH:   byte_in = bit_len[{len_sel, 3'b000} +: 8];
      default:      byte_in = 8'h00;
    endcase
  end

  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
  assign w_t   = (cmd.rnd[5:4] == 2'b00) ? win[0] : w_new;
  assign ch    = (rv[4] & rv[5]) ^ (~rv[4] & rv[6]);
  assign maj   = (rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]);
  assign t1    = rv[7] + bsig1(rv[4]) + ch + ROUND_CONST[cmd.rnd] + w_t;
  assign t2    = bsig0(rv[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i + 1][31:24]};
      end
      win[15] <= {win[15][23:0], byte_in};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_t;
    end

    if (cmd.init_rounds) begin
      for (int i = 0; i < 8; i++) begin
        rv[i] <= hash[i];
      end
    end else if (cmd.round) begin
      rv[7] <= rv[6];
      rv[6] <= rv[5];
      rv[5] <= rv[4];
      rv[4] <= rv[3] + t1;
      rv[3] <= rv[2];
      rv[2] <= rv[1];
      rv[1] <= rv[0];
      rv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= INIT_VECTOR[i];
      end
      fill_pos   <= '0;
      byte_count <= '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + rv[i];
        end
      end
      if (cmd.load) begin
        fill_pos <= fill_pos + 6'd1;
      end
      if (cmd.count) begin
        byte_count <= byte_count + 61'd1;
      end
    end
  end

endmodule

[rtl/sha256_byte_stream_hash_unit.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash_unit
// SHA-256 hash of a byte stream, digest returned as eight 32-bit words.
// ----------------------------------------------------------------------------
// A message byte is taken whenever s_tready is high. When a byte completes a
// 64-byte block the input stalls while the single round unit runs the 64
// rounds and the result is folded into the chained hash. At end of message the
// padding bytes are shifted into the block one per cycle (up to 64 bytes, or
// up to 72 when the length needs an extra block), each padded block stalls
// the same way, and then the eight digest words are offered in order, one
// transfer per cycle while m_tready is high. The input accepts again after
// the last word. An item with tuser low and tlast low is a no-op.
module sha256_byte_stream_hash_unit import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha256_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte_valid (s_tuser),
    .in_eom        (s_tlast),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_idx       (m_tuser),
    .out_last      (m_tlast),
    .cmd           (cmd),
    .status        (status)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .digest_word (m_tdata)
  );

endmodule

[rtl/sha256_chk.sv]
// ----------------------------------------------------------------------------
// sha256_chk
// Port-level checks of the hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_chk import sha256_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // input is closed while the digest is read out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during digest readout");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest words out of order");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tuser == 3'd0) && !m_tlast)
    else $error("digest does not start at word 0");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("unit not idle after last digest word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

endmodule

bind sha256_byte_stream_hash_unit sha256_chk u_chk (.*);
